// ===== rtl/ptst_pkg.sv =====
// shared types and constants for the periodic timer slot table
`timescale 1ns / 1ps
`default_nettype none
package ptst_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [15:0] RUNS_FOREVER = 16'hFFFF;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_FREE     = 2'd2;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [SLOTS-1:0]  use_vec_t;
    typedef logic [7:0]        mask_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] interval;
        logic [15:0] run_count;
        logic [2:0]  slot;
    } ptst_in_t;

    typedef struct packed {
        logic [2:0] granted_slot;
        logic       status;
        mask_t      fired_mask;
        mask_t      released_mask;
    } ptst_out_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] period;
        logic [15:0] runs;
    } slot_data_t;

    typedef struct packed {
        logic        valid;
        slot_idx_t   idx;
        logic        set_use;
        logic        clr_use;
        logic        data_we;
        logic        period_we;
        logic [15:0] count;
        logic [15:0] period;
        logic [15:0] runs;
    } store_wr_t;

    typedef struct packed {
        logic        fire;
        logic        expire;
        logic [15:0] count;
        logic [15:0] runs;
    } alu_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_REG,
        ST_FREE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/ptst_slot_alu.sv =====
// shared slot update unit: fire test, count step and run decrement
`timescale 1ns / 1ps
`default_nettype none
module ptst_slot_alu (
    input  ptst_pkg::slot_data_t cur,
    output ptst_pkg::alu_res_t   res
);

    logic expire;
    logic fire;

    assign expire = (cur.runs == 16'd0);
    assign fire   = !expire && (cur.count >= cur.period);

    always_comb begin
        res.fire   = fire;
        res.expire = expire;
        if (expire) begin
            res.count = cur.count;
        end else if (fire) begin
            res.count = 16'd0;
        end else begin
            res.count = cur.count + 16'd1;
        end
        if (fire && (cur.runs != ptst_pkg::RUNS_FOREVER)) begin
            res.runs = cur.runs - 16'd1;
        end else begin
            res.runs = cur.runs;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ptst_slot_store.sv =====
// slot table storage: in-use flags, counts, periods and remaining runs
`timescale 1ns / 1ps
`default_nettype none
module ptst_slot_store (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  ptst_pkg::store_wr_t   wr,
    input  ptst_pkg::slot_idx_t   rd_idx,
    output ptst_pkg::use_vec_t    in_use,
    output ptst_pkg::slot_data_t  rd_data
);

    ptst_pkg::use_vec_t in_use_reg;
    logic [15:0] count_reg  [ptst_pkg::SLOTS];
    logic [15:0] period_reg [ptst_pkg::SLOTS];
    logic [15:0] runs_reg   [ptst_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (wr.valid) begin
            if (wr.set_use) begin
                in_use_reg[wr.idx] <= 1'b1;
            end else if (wr.clr_use) begin
                in_use_reg[wr.idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.valid && wr.data_we) begin
            count_reg[wr.idx] <= wr.count;
            runs_reg[wr.idx]  <= wr.runs;
        end
        if (wr.valid && wr.period_we) begin
            period_reg[wr.idx] <= wr.period;
        end
    end

    assign in_use         = in_use_reg;
    assign rd_data.count  = count_reg[rd_idx];
    assign rd_data.period = period_reg[rd_idx];
    assign rd_data.runs   = runs_reg[rd_idx];

endmodule
`default_nettype wire

// ===== rtl/periodic_timer_slot_table.sv =====
// top level: slot walk sequencer, result register and handshakes
// a tick visits every slot; a register visits slots up to the first free one
// or the last; a free clears the named slot; an unused code returns an empty result
// s_ready rises with m_valid, when the result moves into the output register
// one slot is visited per cycle; a new item is taken even while a result waits
// reset (aresetn low, synchronous) frees every slot and empties the result register
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_slot_table (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  ptst_pkg::ptst_in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output ptst_pkg::ptst_out_t m_data
);

    ptst_pkg::state_t    state_reg, state_next;
    ptst_pkg::slot_idx_t idx_reg, idx_next;
    ptst_pkg::ptst_in_t  req_reg;
    ptst_pkg::ptst_out_t res_reg, res_next;
    ptst_pkg::ptst_out_t m_data_reg;
    logic                m_valid_reg, m_valid_next;

    ptst_pkg::store_wr_t  wr;
    ptst_pkg::use_vec_t   in_use;
    ptst_pkg::slot_data_t cur;
    ptst_pkg::alu_res_t   alu;

    logic accept;
    logic last_slot;
    logic out_free;
    logic free_ok;

    ptst_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_idx  (idx_reg),
        .in_use  (in_use),
        .rd_data (cur)
    );

    ptst_slot_alu u_alu (
        .cur (cur),
        .res (alu)
    );

    assign s_ready   = (state_reg == ptst_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign last_slot = (idx_reg == ptst_pkg::slot_idx_t'(ptst_pkg::SLOTS - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign free_ok   = (5'(req_reg.slot) < 5'(ptst_pkg::SLOTS));
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptst_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        ptst_pkg::ACT_TICK:     state_next = ptst_pkg::ST_TICK;
                        ptst_pkg::ACT_REGISTER: state_next = ptst_pkg::ST_REG;
                        ptst_pkg::ACT_FREE:     state_next = ptst_pkg::ST_FREE;
                        default:                state_next = ptst_pkg::ST_DONE;
                    endcase
                end
            end
            ptst_pkg::ST_TICK: begin
                if (last_slot) begin
                    state_next = ptst_pkg::ST_DONE;
                end
            end
            ptst_pkg::ST_REG: begin
                if (!in_use[idx_reg] || last_slot) begin
                    state_next = ptst_pkg::ST_DONE;
                end
            end
            ptst_pkg::ST_FREE: begin
                state_next = ptst_pkg::ST_DONE;
            end
            ptst_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ptst_pkg::ST_IDLE;
                end
            end
            default: state_next = ptst_pkg::ST_IDLE;
        endcase
    end

    // datapath control and store writes
    always_comb begin
        idx_next     = idx_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr           = '0;
        wr.idx       = idx_reg;
        unique case (state_reg)
            ptst_pkg::ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    res_next = '0;
                end
            end
            ptst_pkg::ST_TICK: begin
                if (in_use[idx_reg]) begin
                    wr.valid   = 1'b1;
                    wr.data_we = 1'b1;
                    wr.clr_use = alu.expire;
                    wr.count   = alu.count;
                    wr.runs    = alu.runs;
                    res_next.fired_mask = res_reg.fired_mask
                        | (ptst_pkg::mask_t'(alu.fire) << idx_reg);
                    res_next.released_mask = res_reg.released_mask
                        | (ptst_pkg::mask_t'(alu.expire) << idx_reg);
                end
                idx_next = idx_reg + ptst_pkg::slot_idx_t'(1);
            end
            ptst_pkg::ST_REG: begin
                if (!in_use[idx_reg]) begin
                    wr.valid     = 1'b1;
                    wr.set_use   = 1'b1;
                    wr.data_we   = 1'b1;
                    wr.period_we = 1'b1;
                    wr.count     = 16'd0;
                    wr.period    = req_reg.interval;
                    wr.runs      = req_reg.run_count;
                    res_next.granted_slot = 3'(idx_reg);
                end else if (last_slot) begin
                    res_next.status = 1'b1;
                end
                idx_next = idx_reg + ptst_pkg::slot_idx_t'(1);
            end
            ptst_pkg::ST_FREE: begin
                wr.valid   = free_ok;
                wr.clr_use = 1'b1;
                wr.idx     = ptst_pkg::slot_idx_t'(req_reg.slot);
            end
            ptst_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptst_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (accept) begin
            req_reg <= s_data;
        end
        if ((state_reg == ptst_pkg::ST_DONE) && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while sequencer busy");

    a_fire_release_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.fired_mask & m_data_reg.released_mask) == 8'd0))
        else $error("slot both fired and released on one tick");

    a_released_not_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ((m_data_reg.released_mask & 8'(in_use)) == 8'd0))
        else $error("released slot still marked in use");

    a_full_means_all_used: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_data_reg.status) |-> (&in_use))
        else $error("register failed while a slot was free");

endmodule
`default_nettype wire

// ===== sim/ptst_checker.sv =====
// checker for the periodic timer slot table: predicts each result and compares it
`timescale 1ns / 1ps
module ptst_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  ptst_pkg::ptst_in_t  s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  ptst_pkg::ptst_out_t m_data,
    input  wire                 end_of_test,
    output int                  mismatch_count,
    output int                  pending_results
);

    logic        armed       [ptst_pkg::SLOTS];
    logic [15:0] slot_count  [ptst_pkg::SLOTS];
    logic [15:0] slot_period [ptst_pkg::SLOTS];
    logic [15:0] slot_runs   [ptst_pkg::SLOTS];

    ptst_pkg::ptst_out_t expected_results [$];
    ptst_pkg::ptst_out_t want;
    int                  results_seen;
    bit                  leftovers_checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    function automatic ptst_pkg::ptst_out_t predict_slot_table(input ptst_pkg::ptst_in_t req);
        ptst_pkg::ptst_out_t res;
        bit                  found;
        int                  i;
        res   = '0;
        found = 1'b0;
        case (req.action)
            ptst_pkg::ACT_TICK: begin
                for (i = 0; i < ptst_pkg::SLOTS; i++) begin
                    if (armed[i]) begin
                        if (slot_runs[i] != 16'd0) begin
                            if (slot_count[i] >= slot_period[i]) begin
                                if (i < 8) res.fired_mask[i] = 1'b1;
                                slot_count[i] = 16'd0;
                                if (slot_runs[i] != ptst_pkg::RUNS_FOREVER)
                                    slot_runs[i] = slot_runs[i] - 16'd1;
                            end else begin
                                slot_count[i] = slot_count[i] + 16'd1;
                            end
                        end else begin
                            armed[i] = 1'b0;
                            if (i < 8) res.released_mask[i] = 1'b1;
                        end
                    end
                end
            end
            ptst_pkg::ACT_REGISTER: begin
                res.status = 1'b1;
                for (i = 0; i < ptst_pkg::SLOTS; i++) begin
                    if (!found && !armed[i]) begin
                        found            = 1'b1;
                        armed[i]         = 1'b1;
                        slot_count[i]    = 16'd0;
                        slot_period[i]   = req.interval;
                        slot_runs[i]     = req.run_count;
                        res.granted_slot = 3'(i);
                        res.status       = 1'b0;
                    end
                end
            end
            ptst_pkg::ACT_FREE: begin
                if (int'(req.slot) < ptst_pkg::SLOTS) armed[req.slot] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
                armed[i]       = 1'b0;
                slot_count[i]  = 16'd0;
                slot_period[i] = 16'd0;
                slot_runs[i]   = 16'd0;
            end
            expected_results.delete();
            mismatch_count    = 0;
            results_seen      = 0;
            leftovers_checked = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.granted_slot !== want.granted_slot)
                        report_mismatch($sformatf("granted_slot got %0d want %0d",
                                                  m_data.granted_slot, want.granted_slot));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_data.status, want.status));
                    if (m_data.fired_mask !== want.fired_mask)
                        report_mismatch($sformatf("fired_mask got %02h want %02h",
                                                  m_data.fired_mask, want.fired_mask));
                    if (m_data.released_mask !== want.released_mask)
                        report_mismatch($sformatf("released_mask got %02h want %02h",
                                                  m_data.released_mask, want.released_mask));
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_slot_table(s_data));
            if (end_of_test && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_results.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_results.size()));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// ===== sim/tb_periodic_timer_slot_table.sv =====
// testbench top for the periodic timer slot table: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module tb_periodic_timer_slot_table;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1550;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 400;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    ptst_pkg::ptst_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    ptst_pkg::ptst_out_t m_data;
    logic                end_of_test;
    logic                hold_req;
    int                  mismatch_count;
    int                  pending_results;
    int                  cycle_count = 0;
    int                  burst_left;
    int                  items_sent;

    always #5 aclk = ~aclk;

    periodic_timer_slot_table u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ptst_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .end_of_test     (end_of_test),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic ptst_pkg::ptst_in_t make_req(input logic [1:0] action,
                                                    input logic [15:0] interval,
                                                    input logic [15:0] run_count,
                                                    input logic [2:0] slot);
        ptst_pkg::ptst_in_t req;
        req.action    = action;
        req.interval  = interval;
        req.run_count = run_count;
        req.slot      = slot;
        return req;
    endfunction

    function automatic ptst_pkg::ptst_in_t random_req();
        ptst_pkg::ptst_in_t req;
        int                 pick;
        int                 shape;
        req.interval  = 16'($urandom_range(65535));
        req.run_count = 16'($urandom_range(65535));
        req.slot      = 3'($urandom_range(7));
        pick          = $urandom_range(99);
        shape         = $urandom_range(9);
        if (pick < 50) begin
            req.action = ptst_pkg::ACT_TICK;
        end else if (pick < 78) begin
            req.action = ptst_pkg::ACT_REGISTER;
            if (shape < 6) begin
                req.interval  = 16'($urandom_range(3));
                req.run_count = 16'($urandom_range(4));
            end else if (shape < 8) begin
                req.interval  = 16'($urandom_range(4));
                req.run_count = ptst_pkg::RUNS_FOREVER;
            end
        end else if (pick < 95) begin
            req.action = ptst_pkg::ACT_FREE;
        end else begin
            req.action = ACT_UNUSED;
        end
        return req;
    endfunction

    task automatic issue_request(input ptst_pkg::ptst_in_t req);
        int gap;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(9) < 3) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    initial begin : receiver
        int  mode;
        int  stretch;
        bit  held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode    = $urandom_range(2);
            stretch = $urandom_range(60, 8);
            repeat (stretch) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(3) != 0);
                    default: m_ready <= ($urandom_range(3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        ptst_pkg::ptst_in_t directed_items [$];
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        end_of_test <= 1'b0;
        hold_req    <= 1'b0;
        burst_left   = 0;
        items_sent   = 0;

        // empty table, unused code, frees of idle slots
        directed_items.push_back(make_req(ptst_pkg::ACT_TICK, 16'h0000, 16'h0000, 3'd0));
        directed_items.push_back(make_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7));
        directed_items.push_back(make_req(ptst_pkg::ACT_FREE, 16'hFFFF, 16'hFFFF, 3'd7));
        directed_items.push_back(make_req(ptst_pkg::ACT_FREE, 16'h0000, 16'h0000, 3'd0));
        // fill every slot, zero run count and unlimited among them, then one too many
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0000, 16'h0000, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'hFFFF,
                                          ptst_pkg::RUNS_FOREVER, 3'd7));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0001, 16'h0002, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0000,
                                          ptst_pkg::RUNS_FOREVER, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0002, 16'h0001, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0000, 16'h0001, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0003, 16'h0003, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'hFFFF, 16'h0000, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0005, 16'h0005, 3'd0));
        repeat (4) directed_items.push_back(make_req(ptst_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF,
                                                     3'd7));
        directed_items.push_back(make_req(ptst_pkg::ACT_FREE, 16'h0000, 16'h0000, 3'd1));
        directed_items.push_back(make_req(ptst_pkg::ACT_FREE, 16'h0000, 16'h0000, 3'd1));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0001,
                                          ptst_pkg::RUNS_FOREVER, 3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_REGISTER, 16'h0000, 16'h0000, 3'd0));
        repeat (3) directed_items.push_back(make_req(ptst_pkg::ACT_TICK, 16'h0000, 16'h0000,
                                                     3'd0));
        directed_items.push_back(make_req(ptst_pkg::ACT_FREE, 16'h0000, 16'h0000, 3'd7));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_items[k]) issue_request(directed_items[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_req <= 1'b1;
            if (n == 900) drain_results();
            issue_request(random_req());
        end

        drain_results();
        repeat (20) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
